// ===== rtl/core/fixed_width_decimal_formatter_unit_assert.svh =====
// assertion macros for the decimal formatter checker
// no dependencies
`ifndef FIXED_WIDTH_DECIMAL_FORMATTER_UNIT_ASSERT_SVH
`define FIXED_WIDTH_DECIMAL_FORMATTER_UNIT_ASSERT_SVH
// implication checked outside reset
`define FWDF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
// implication checked at every edge, reset included
`define FWDF_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== rtl/core/fwdf_pkg.sv =====
// shared types and constants of the decimal formatter
// no dependencies
package fwdf_pkg;
   localparam int VALUE_BITS = 48;
   localparam int FRAC_BITS_DEF = 24;
   localparam int MAX_INT_DIGITS_DEF = 8;
   localparam int MAX_FRAC_DIGITS = 6;
   localparam int STEP_BITS = 4;
   localparam logic [7:0] ASCII_ZERO = 8'd48;
   localparam logic [7:0] MINUS_CHAR = 8'h2d;
   localparam logic [7:0] POINT_CHAR = 8'h2e;

   typedef struct packed {
      logic       neg;
      logic [3:0] w;
      logic [2:0] f;
      logic [7:0] fill;
   } side_type;
endpackage

// ===== rtl/core/fixed_width_decimal_formatter_unit.sv =====
// path to the first character: input register, the NSTG bcd stages, serializer registers
// throughput (set by the serializer): one character per cycle while rsp_tready is high,
// w + (f ? f+1 : 0) characters per number (1 to 15); the bcd stages take a new value every
// cycle unless stalled; reset clears all stage valid bits and the serializer busy flag
// depends on fwdf_pkg, fwdf_bcd_stage, fwdf_emit
module fixed_width_decimal_formatter_unit #(
   parameter int FRAC_BITS = fwdf_pkg::FRAC_BITS_DEF,
   parameter int MAX_INT_DIGITS = fwdf_pkg::MAX_INT_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // value[47:0], int_digits[51:48], frac_digits[54:52],
                                   // fill_char[62:55]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // character[7:0]
   output logic        rsp_tlast,
   output logic        rsp_tuser   // overflow[0]
);
   import fwdf_pkg::*;

   localparam int IW   = VALUE_BITS - FRAC_BITS;
   localparam int NSTG = (IW + STEP_BITS - 1) / STEP_BITS;
   localparam int PW   = NSTG * STEP_BITS;
   localparam int ND   = (IW * 1233) / 4096 + 1;

   logic [VALUE_BITS-1:0] v, mag;
   logic [3:0]            w_raw, w_in;
   logic [2:0]            f_raw, f_in;

   logic                  vld [NSTG+1];
   logic                  rdy [NSTG+1];
   logic [PW-1:0]         bin [NSTG+1];
   logic [ND*4-1:0]       bcd [NSTG+1];
   side_type              side [NSTG+1];
   logic [FRAC_BITS-1:0]  frac [NSTG+1];

   logic                  v0_ff;
   logic [PW-1:0]         bin0_ff;
   side_type              side0_ff, side0_in;
   logic [FRAC_BITS-1:0]  frac0_ff;

   assign v     = req_tdata[VALUE_BITS-1:0];
   assign w_raw = req_tdata[51:48];
   assign f_raw = req_tdata[54:52];
   assign mag   = v[VALUE_BITS-1] ? (~v + 1'b1) : v;

   always_comb begin
      if (w_raw == 4'd0) begin
         w_in = 4'd1;
      end else if (w_raw > 4'(MAX_INT_DIGITS)) begin
         w_in = 4'(MAX_INT_DIGITS);
      end else begin
         w_in = w_raw;
      end
      f_in = (f_raw > 3'(MAX_FRAC_DIGITS)) ? 3'(MAX_FRAC_DIGITS) : f_raw;
      side0_in.neg  = v[VALUE_BITS-1];
      side0_in.w    = w_in;
      side0_in.f    = f_in;
      side0_in.fill = req_tdata[62:55];
   end

   assign req_tready = !v0_ff || rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (req_tready) begin
         v0_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         bin0_ff  <= PW'(mag[VALUE_BITS-1:FRAC_BITS]);
         side0_ff <= side0_in;
         frac0_ff <= mag[FRAC_BITS-1:0];
      end
   end

   assign vld[0]  = v0_ff;
   assign bin[0]  = bin0_ff;
   assign bcd[0]  = '0;
   assign side[0] = side0_ff;
   assign frac[0] = frac0_ff;

   for (genvar g = 0; g < NSTG; g++) begin : g_stage
      fwdf_bcd_stage #(.PW(PW), .ND(ND), .FB(FRAC_BITS)) u_stage (
         .clock   (clock),
         .reset   (reset),
         .valid_i (vld[g]),
         .ready_o (rdy[g]),
         .bin_i   (bin[g]),
         .bcd_i   (bcd[g]),
         .side_i  (side[g]),
         .frac_i  (frac[g]),
         .valid_o (vld[g+1]),
         .ready_i (rdy[g+1]),
         .bin_o   (bin[g+1]),
         .bcd_o   (bcd[g+1]),
         .side_o  (side[g+1]),
         .frac_o  (frac[g+1])
      );
   end

   fwdf_emit #(.ND(ND), .FB(FRAC_BITS)) u_emit (
      .clock     (clock),
      .reset     (reset),
      .valid_i   (vld[NSTG]),
      .ready_o   (rdy[NSTG]),
      .bcd_i     (bcd[NSTG]),
      .side_i    (side[NSTG]),
      .frac_i    (frac[NSTG]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_ovf   (rsp_tuser)
   );
endmodule

// ===== rtl/core/fwdf_bcd_stage.sv =====
// one double-dabble pipeline stage, shifts STEP_BITS binary bits into bcd digits
// depends on fwdf_pkg
module fwdf_bcd_stage #(
   parameter int PW = 24,
   parameter int ND = 8,
   parameter int FB = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_i,
   output logic               ready_o,
   input  logic [PW-1:0]      bin_i,
   input  logic [ND*4-1:0]    bcd_i,
   input  fwdf_pkg::side_type side_i,
   input  logic [FB-1:0]      frac_i,
   output logic               valid_o,
   input  logic               ready_i,
   output logic [PW-1:0]      bin_o,
   output logic [ND*4-1:0]    bcd_o,
   output fwdf_pkg::side_type side_o,
   output logic [FB-1:0]      frac_o
);
   import fwdf_pkg::*;

   logic            valid_ff;
   logic [PW-1:0]   bin_ff, bin_in;
   logic [ND*4-1:0] bcd_ff, bcd_in;
   side_type        side_ff;
   logic [FB-1:0]   frac_ff;

   assign ready_o = !valid_ff || ready_i;

   always_comb begin
      bin_in = bin_i;
      bcd_in = bcd_i;
      for (int s = 0; s < STEP_BITS; s++) begin
         for (int d = 0; d < ND; d++) begin
            if (bcd_in[d*4 +: 4] >= 4'd5) begin
               bcd_in[d*4 +: 4] = bcd_in[d*4 +: 4] + 4'd3;
            end
         end
         bcd_in = {bcd_in[ND*4-2:0], bin_in[PW-1]};
         bin_in = {bin_in[PW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_o) begin
         valid_ff <= valid_i;
      end
      if (ready_o && valid_i) begin
         bin_ff  <= bin_in;
         bcd_ff  <= bcd_in;
         side_ff <= side_i;
         frac_ff <= frac_i;
      end
   end

   assign valid_o = valid_ff;
   assign bin_o   = bin_ff;
   assign bcd_o   = bcd_ff;
   assign side_o  = side_ff;
   assign frac_o  = frac_ff;
endmodule

// ===== rtl/core/fwdf_emit.sv =====
// character serializer: builds the integer field, point and fraction digits
// depends on fwdf_pkg
module fwdf_emit #(
   parameter int ND = 8,
   parameter int FB = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_i,
   output logic               ready_o,
   input  logic [ND*4-1:0]    bcd_i,
   input  fwdf_pkg::side_type side_i,
   input  logic [FB-1:0]      frac_i,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         out_char,
   output logic               out_last,
   output logic               out_ovf
);
   import fwdf_pkg::*;

   logic            busy_ff;
   logic [4:0]      pos_ff, total_ff, nd_ff;
   logic [ND*4-1:0] bcd_ff;
   side_type        side_ff;
   logic [FB-1:0]   frac_ff;
   logic            ovf_ff;

   logic [4:0]      nd_in, need, total_in, r;
   logic [3:0]      dig;
   logic [FB+3:0]   t;
   logic            fire;

   always_comb begin
      nd_in = 5'd1;
      for (int d = 1; d < ND; d++) begin
         if (bcd_i[d*4 +: 4] != 4'd0) begin
            nd_in = 5'(d + 1);
         end
      end
      need = nd_in + {4'd0, side_i.neg};
      total_in = {1'b0, side_i.w} +
                 ((side_i.f != 3'd0) ? ({2'd0, side_i.f} + 5'd1) : 5'd0);
   end

   assign t = ({4'd0, frac_ff} << 3) + ({4'd0, frac_ff} << 1);
   assign r = {1'b0, side_ff.w} - 5'd1 - pos_ff;

   always_comb begin
      dig = 4'd0;
      for (int d = 0; d < ND; d++) begin
         if (r == 5'(d)) begin
            dig = bcd_ff[d*4 +: 4];
         end
      end
   end

   always_comb begin
      if (pos_ff < {1'b0, side_ff.w}) begin
         if (r < nd_ff) begin
            out_char = ASCII_ZERO + {4'd0, dig};
         end else if (r == nd_ff && side_ff.neg) begin
            out_char = MINUS_CHAR;
         end else begin
            out_char = side_ff.fill;
         end
      end else if (pos_ff == {1'b0, side_ff.w}) begin
         out_char = POINT_CHAR;
      end else begin
         out_char = ASCII_ZERO + {4'd0, t[FB+3:FB]};
      end
   end

   assign out_valid = busy_ff;
   assign out_last  = (pos_ff == total_ff - 5'd1);
   assign out_ovf   = ovf_ff;
   assign fire      = busy_ff && out_ready;
   assign ready_o   = !busy_ff || (out_ready && out_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= 5'd0;
      end else if (ready_o && valid_i) begin
         busy_ff <= 1'b1;
         pos_ff  <= 5'd0;
      end else if (fire) begin
         if (out_last) begin
            busy_ff <= 1'b0;
         end
         pos_ff <= pos_ff + 5'd1;
      end
      if (ready_o && valid_i) begin
         bcd_ff   <= bcd_i;
         side_ff  <= side_i;
         frac_ff  <= frac_i;
         nd_ff    <= nd_in;
         total_ff <= total_in;
         ovf_ff   <= (need > {1'b0, side_i.w});
      end else if (fire && pos_ff > {1'b0, side_ff.w}) begin
         frac_ff <= t[FB-1:0];
      end
   end
endmodule

// ===== rtl/core/fwdf_checker.sv =====
// port-level checker for the decimal formatter, bound to the top level
// depends on fixed_width_decimal_formatter_unit_assert.svh
`include "fixed_width_decimal_formatter_unit_assert.svh"
module fwdf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);
   logic [9:0] rsp_word;

   assign rsp_word = {rsp_tdata, rsp_tlast, rsp_tuser};

   `FWDF_ASSERT_IMPL(a_valid_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `FWDF_ASSERT_IMPL(a_data_holds, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_word))
   `FWDF_ASSERT_IMPL(a_no_gap, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid)
   `FWDF_ASSERT_ALWAYS(a_reset_idle, clock, reset, !rsp_tvalid)
endmodule

bind fixed_width_decimal_formatter_unit fwdf_checker u_fwdf_checker (.*);
